@@ src/lrupr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths and the lookup result type.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int unsigned PAGE_NUMBER_W = 16;
  localparam int unsigned FRAME_INDEX_W = 4;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned WIDE_W        = 32;
  localparam int unsigned OUT_DATA_W    = 88;

  // Outcome of one page reference against the frame set
  typedef struct packed {
    logic                     hit;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic                     evicted_valid;
    logic [PAGE_NUMBER_W-1:0] evicted_page;
  } lookup_t;

endpackage

@@ src/lrupr_frame_set.sv @@
// ----------------------------------------------------------------------------
// LRU frame set
// Frame contents, valid bits and recency ranks; parallel lookup and update.
// ----------------------------------------------------------------------------
module lrupr_frame_set #(
  parameter int unsigned NUM_FRAMES = 3,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                update,
  input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0] page_number,
  output lrupr_pkg::lookup_t                  lookup
);

  localparam int unsigned RW = $clog2(NUM_FRAMES);

  logic [PAGE_BITS-1:0]  frame_page [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] frame_valid;
  logic [RW-1:0]         recency_rank [NUM_FRAMES];

  logic [lrupr_pkg::WIDE_W-1:0] page_wide;
  logic [lrupr_pkg::WIDE_W-1:0] evict_wide;
  logic [PAGE_BITS-1:0]         page;
  logic [NUM_FRAMES-1:0]        match_vec;
  logic [NUM_FRAMES-1:0]        empty_vec;
  logic [NUM_FRAMES-1:0]        oldest_vec;
  logic [RW-1:0]                found_idx;
  logic [RW-1:0]                empty_idx;
  logic [RW-1:0]                victim_idx;
  logic [RW-1:0]                sel_idx;
  logic                         found_any;
  logic                         empty_any;
  logic [RW-1:0]                hit_rank;
  logic [RW-1:0]                rank_next [NUM_FRAMES];

  assign page_wide = lrupr_pkg::WIDE_W'(page_number);
  assign page      = page_wide[PAGE_BITS-1:0];

  always_comb begin
    for (int k = 0; k < NUM_FRAMES; k++) begin
      match_vec[k]  = frame_valid[k] && (frame_page[k] == page);
      empty_vec[k]  = !frame_valid[k];
      oldest_vec[k] = frame_valid[k] && (recency_rank[k] == RW'(NUM_FRAMES - 1));
    end
  end

  // lowest-index priority encoders
  always_comb begin
    found_idx  = '0;
    empty_idx  = '0;
    victim_idx = '0;
    for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        found_idx = RW'(k);
      end
      if (empty_vec[k]) begin
        empty_idx = RW'(k);
      end
      if (oldest_vec[k]) begin
        victim_idx = RW'(k);
      end
    end
  end

  assign found_any = |match_vec;
  assign empty_any = |empty_vec;
  assign hit_rank  = recency_rank[found_idx];

  always_comb begin
    if (found_any) begin
      sel_idx = found_idx;
    end else if (empty_any) begin
      sel_idx = empty_idx;
    end else begin
      sel_idx = victim_idx;
    end
  end

  // on a hit only the more recent frames age; otherwise every valid frame does
  always_comb begin
    for (int k = 0; k < NUM_FRAMES; k++) begin
      if (RW'(k) == sel_idx) begin
        rank_next[k] = '0;
      end else if (frame_valid[k] && (!found_any || (recency_rank[k] < hit_rank))) begin
        rank_next[k] = recency_rank[k] + RW'(1);
      end else begin
        rank_next[k] = recency_rank[k];
      end
    end
  end

  assign evict_wide = lrupr_pkg::WIDE_W'(frame_page[victim_idx]);

  always_comb begin
    lookup.hit           = found_any;
    lookup.frame_index   = lrupr_pkg::FRAME_INDEX_W'(sel_idx);
    lookup.evicted_valid = !found_any && !empty_any;
    lookup.evicted_page  = lookup.evicted_valid ?
                           evict_wide[lrupr_pkg::PAGE_NUMBER_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        recency_rank[k] <= '0;
      end
    end else if (update) begin
      for (int k = 0; k < NUM_FRAMES; k++) begin
        recency_rank[k] <= rank_next[k];
        if (RW'(k) == sel_idx) begin
          frame_valid[k] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update && !found_any) begin
      frame_page[sel_idx] <= page;
    end
  end

endmodule

@@ src/lrupr_stat_counters.sv @@
// ----------------------------------------------------------------------------
// LRU statistics counters
// Saturating hit and fault counts; presents the values after this reference.
// ----------------------------------------------------------------------------
module lrupr_stat_counters (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          update,
  input  logic                          hit,
  output logic [lrupr_pkg::TOTAL_W-1:0] hit_total_next,
  output logic [lrupr_pkg::TOTAL_W-1:0] fault_total_next
);

  logic [lrupr_pkg::TOTAL_W-1:0] hit_counter;
  logic [lrupr_pkg::TOTAL_W-1:0] fault_counter;

  always_comb begin
    hit_total_next   = hit_counter;
    fault_total_next = fault_counter;
    if (hit) begin
      if (hit_counter != '1) begin
        hit_total_next = hit_counter + lrupr_pkg::TOTAL_W'(1);
      end
    end else begin
      if (fault_counter != '1) begin
        fault_total_next = fault_counter + lrupr_pkg::TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter   <= '0;
      fault_counter <= '0;
    end else if (update) begin
      hit_counter   <= hit_total_next;
      fault_counter <= fault_total_next;
    end
  end

endmodule

@@ src/lru_page_replacement_top.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement top level
// Fully associative page frame set under least-recently-used replacement.
// ----------------------------------------------------------------------------
// One page reference is taken per cycle and gives one result word, through
// the input register, then the result register. Throughput is one word per
// clock while not stalled: the frame compare, victim pick and rank update
// all close between the input register and the result register, and that loop
// through the frame state sets the rate. While a result word waits, the input
// register can take one more word, then it holds that word and the input
// stalls until the result is taken. After reset all frames are empty.
module lru_page_replacement_top #(
  parameter int unsigned NUM_FRAMES = 3,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] page_number
  input  logic [lrupr_pkg::PAGE_NUMBER_W-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] hit, [4:1] frame_index, [5] evicted_valid, [21:6] evicted_page,
  // [53:22] hit_total, [85:54] fault_total, [87:86] zero
  output logic [lrupr_pkg::OUT_DATA_W-1:0]    m_tdata
);

  logic                                in_vld;
  logic [lrupr_pkg::PAGE_NUMBER_W-1:0] in_page;
  logic                                out_vld;
  logic [lrupr_pkg::OUT_DATA_W-1:0]    out_data;
  logic                                advance;
  lrupr_pkg::lookup_t                  lookup;
  logic [lrupr_pkg::TOTAL_W-1:0]       hit_total_next;
  logic [lrupr_pkg::TOTAL_W-1:0]       fault_total_next;

  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;
  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  lrupr_frame_set #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frame_set (
    .clk         (clk),
    .rst         (rst),
    .update      (advance),
    .page_number (in_page),
    .lookup      (lookup)
  );

  lrupr_stat_counters u_counters (
    .clk              (clk),
    .rst              (rst),
    .update           (advance),
    .hit              (lookup.hit),
    .hit_total_next   (hit_total_next),
    .fault_total_next (fault_total_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_page <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {2'b00, fault_total_next, hit_total_next, lookup.evicted_page,
                   lookup.evicted_valid, lookup.frame_index, lookup.hit};
    end
  end

endmodule

@@ src/lrupr_checker.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement port checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lrupr_checker #(
  parameter int unsigned NUM_FRAMES = 3
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [lrupr_pkg::OUT_DATA_W-1:0] m_tdata
);

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // an eviction only happens on a fault
  a_evict_on_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[5] && m_tdata[0]))
    else $error("eviction reported on a hit");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> m_tdata[21:6] == 16'd0)
    else $error("evicted page not zero without eviction");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 32'(m_tdata[4:1]) < NUM_FRAMES)
    else $error("frame index out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word present after reset");

endmodule

bind lru_page_replacement_top lrupr_checker #(
  .NUM_FRAMES (NUM_FRAMES)
) u_lrupr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb_lru_page_replacement_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page references through the stream input and predicts every result
// word with an independent LRU frame model. Results are checked field by
// field in order of arrival. The run starts with a directed part covering
// empty fills, hits at the older recency ranks and evictions. It then
// switches to random references drawn mostly from small changing working
// sets, under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------

typedef struct packed {
  lrupr_pkg::lookup_t look;
  logic [31:0]        hit_total;
  logic [31:0]        fault_total;
  logic [1:0]         pad;
} page_result_t;

class lru_scoreboard;
  localparam int FRAMES = 3;

  bit [15:0]    held_page[FRAMES];
  bit           occupied[FRAMES];
  int unsigned  age_rank[FRAMES];
  bit [31:0]    hit_count;
  bit [31:0]    fault_count;
  page_result_t expected_q[$];
  int           errors;

  function int pending();
    return expected_q.size();
  endfunction

  function bit [31:0] bump(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // frames younger than limit age by one; slot becomes most recent
  function void promote(int slot, int unsigned limit);
    for (int k = 0; k < FRAMES; k++) begin
      if (k != slot && occupied[k] && age_rank[k] < limit) age_rank[k]++;
    end
    age_rank[slot] = 0;
    occupied[slot] = 1'b1;
  endfunction

  function void note_page(logic [15:0] page);
    int           hit_at;
    int           free_at;
    int           victim;
    page_result_t e;
    hit_at  = -1;
    free_at = -1;
    victim  = 0;
    e       = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (occupied[k] && held_page[k] == page && hit_at < 0) hit_at = k;
      if (!occupied[k] && free_at < 0) free_at = k;
    end
    if (hit_at >= 0) begin
      e.look.hit         = 1'b1;
      e.look.frame_index = 4'(hit_at);
      promote(hit_at, age_rank[hit_at]);
      hit_count = bump(hit_count);
    end else if (free_at >= 0) begin
      e.look.frame_index = 4'(free_at);
      promote(free_at, 32'hFF);
      held_page[free_at] = page;
      fault_count = bump(fault_count);
    end else begin
      // oldest frame goes, lowest index on a tie
      for (int k = 1; k < FRAMES; k++) begin
        if (age_rank[k] > age_rank[victim]) victim = k;
      end
      e.look.frame_index   = 4'(victim);
      e.look.evicted_valid = 1'b1;
      e.look.evicted_page  = held_page[victim];
      promote(victim, 32'hFF);
      held_page[victim] = page;
      fault_count = bump(fault_count);
    end
    e.hit_total   = hit_count;
    e.fault_total = fault_count;
    expected_q = {expected_q, e};
  endfunction

  function void check_word(logic [87:0] word);
    page_result_t a;
    page_result_t e;
    a.look.hit           = word[0];
    a.look.frame_index   = word[4:1];
    a.look.evicted_valid = word[5];
    a.look.evicted_page  = word[21:6];
    a.hit_total          = word[53:22];
    a.fault_total        = word[85:54];
    a.pad                = word[87:86];
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word %h", word);
      return;
    end
    e = expected_q.pop_front();
    if (a.look.hit !== e.look.hit || a.look.frame_index !== e.look.frame_index ||
        a.look.evicted_valid !== e.look.evicted_valid ||
        a.look.evicted_page !== e.look.evicted_page ||
        a.hit_total !== e.hit_total || a.fault_total !== e.fault_total ||
        a.pad !== e.pad) begin
      errors++;
      if (errors <= 10) begin
        $display("exp hit=%0d frame=%0d ev=%0d ev_page=%h hits=%0d faults=%0d pad=%0d",
                 e.look.hit, e.look.frame_index, e.look.evicted_valid,
                 e.look.evicted_page, e.hit_total, e.fault_total, e.pad);
        $display("got hit=%0d frame=%0d ev=%0d ev_page=%h hits=%0d faults=%0d pad=%0d",
                 a.look.hit, a.look.frame_index, a.look.evicted_valid,
                 a.look.evicted_page, a.hit_total, a.fault_total, a.pad);
      end
    end
  endfunction
endclass

module tb_lru_page_replacement_top;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 325;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [15:0] pool[6];
  int          pool_size;
  logic [15:0] page;
  logic [15:0] directed_pages[20] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h8001,
    16'hFFFF, 16'h7FFE, 16'h0000, 16'h0001, 16'h0002, 16'h0001, 16'h0003,
    16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555
  };

  lru_scoreboard sb = new();

  lru_page_replacement_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_page(s_tdata);
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_page(input logic [15:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_pages[i]) send_page(directed_pages[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // fresh working set now and then; small page numbers collide more
        if (n % 40 == 0) begin
          pool_size = $urandom_range(2, 6);
          foreach (pool[i]) begin
            pool[i] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(7));
          end
        end
        case ($urandom_range(9))
          8:       page = 16'($urandom);
          9:       page = page;
          default: page = pool[$urandom_range(pool_size - 1)];
        endcase
        send_page(page);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lrupr_pkg.sv
src/lrupr_frame_set.sv
src/lrupr_stat_counters.sv
src/lru_page_replacement_top.sv
src/lrupr_checker.sv
dv/tb_lru_page_replacement_top.sv
